/* rtl/assert_macros.svh */
// Assertion helpers; the enclosing module provides clk and arst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds at every edge out of reset.
`define SRT_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
	else $error(msg);

// Antecedent in this cycle implies consequent in the next one.
`define SRT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error(msg);

`endif

/* rtl/srt_pkg.sv */
package srt_pkg;

	localparam int unsigned DefTableDepth  = 256;
	localparam int unsigned DefAddressBits = 48;

	localparam int unsigned StartW = 48;
	localparam int unsigned LenW   = 49;
	localparam int unsigned TagW   = 4;
	localparam int unsigned IdxW   = 8;
	localparam int unsigned HeldW  = 9;

	typedef enum logic [1:0] {
		ACT_INCLUDE = 2'd0,
		ACT_EXCLUDE = 2'd1,
		ACT_SET     = 2'd2,
		ACT_READ    = 2'd3
	} srt_action_t;

	typedef enum logic [1:0] {
		STAT_OK        = 2'd0,
		STAT_FULL      = 2'd1,
		STAT_BAD_RANGE = 2'd2
	} srt_status_t;

	typedef enum logic [1:0] {
		PH_LEFT,
		PH_MID,
		PH_RIGHT,
		PH_TAIL
	} srt_phase_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CHECK,
		ST_READ,
		ST_READ_WAIT,
		ST_FETCH,
		ST_LOAD,
		ST_PH_LEFT,
		ST_PH_MID,
		ST_PH_RIGHT,
		ST_TAIL,
		ST_FINISH,
		ST_OUT
	} srt_state_t;

	typedef struct packed {
		logic [StartW-1:0] start;
		logic [LenW-1:0]   len;
		logic [TagW-1:0]   tag;
	} srt_entry_t;

	typedef struct packed {
		logic       capture;
		logic       quick;
		logic       walk_init;
		logic       rd_idx;
		logic       load;
		logic       step;
		srt_phase_t phase;
		logic       read_take;
		logic       commit;
	} srt_cmd_t;

	typedef struct packed {
		logic is_read;
		logic skip;
		logic more;
	} srt_stat_t;

endpackage

/* rtl/srt_in_if.sv */
interface srt_in_if;
	import srt_pkg::*;
	logic              valid;
	logic              ready;
	logic [1:0]        action;
	logic [StartW-1:0] range_start;
	logic [LenW-1:0]   range_length;
	logic [TagW-1:0]   region_tag;
	logic [IdxW-1:0]   read_index;

	modport source (output valid, action, range_start, range_length, region_tag, read_index,
		input ready);
	modport sink (input valid, action, range_start, range_length, region_tag, read_index,
		output ready);
endinterface

/* rtl/srt_out_if.sv */
interface srt_out_if;
	import srt_pkg::*;
	logic              valid;
	logic              ready;
	logic [1:0]        status;
	logic [StartW-1:0] entry_start;
	logic [LenW-1:0]   entry_length;
	logic [TagW-1:0]   entry_tag;
	logic              entry_valid;
	logic [HeldW-1:0]  regions_held;

	modport source (output valid, status, entry_start, entry_length, entry_tag, entry_valid,
		regions_held, input ready);
	modport sink (input valid, status, entry_start, entry_length, entry_tag, entry_valid,
		regions_held, output ready);
endinterface

/* rtl/sorted_region_table_core.sv */
// Sorted region table: disjoint address regions kept in start order, 4-bit kind tag each.
// req (sink): one word per operation - action (include, exclude, set, read), range_start,
//   range_length, region_tag, read_index. req.ready is high only while the block is idle.
// rsp (source): one word per operation - status, the entry read (zero for other actions),
//   entry_valid and the region count after the operation.
// A read passes through check, read and read-wait states before rsp.valid; a zero-length
//   or bad-range operation goes from check straight to the output state. Include, exclude
//   and set copy the live table into a shadow bank: each stored region takes fetch, load
//   and three emit steps, then a tail step and a finish. The table memory has one read port.
// A finished table replaces the live one only if it fits; otherwise the table stays as
//   it was and status reports full.
// Reset clears the region count and the bank select; table contents need no clearing.
// When rsp.ready is low the result holds in the output register and no new word is
//   taken until it is delivered.
module sorted_region_table_core import srt_pkg::*; #(
	parameter int unsigned TABLE_DEPTH  = DefTableDepth,
	parameter int unsigned ADDRESS_BITS = DefAddressBits
) (
	input logic       clk,
	input logic       arst_n,
	srt_in_if.sink    req,
	srt_out_if.source rsp
);
	srt_cmd_t  cmd;
	srt_stat_t stat;

	srt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (req.ready),
		.out_valid(rsp.valid),
		.out_ready(rsp.ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	srt_dp #(
		.TABLE_DEPTH (TABLE_DEPTH),
		.ADDRESS_BITS(ADDRESS_BITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.action      (req.action),
		.range_start (req.range_start),
		.range_length(req.range_length),
		.region_tag  (req.region_tag),
		.read_index  (req.read_index),
		.status      (rsp.status),
		.entry_start (rsp.entry_start),
		.entry_length(rsp.entry_length),
		.entry_tag   (rsp.entry_tag),
		.entry_valid (rsp.entry_valid),
		.regions_held(rsp.regions_held)
	);
endmodule

/* rtl/srt_ram.sv */
module srt_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 2
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

/* rtl/srt_ctrl.sv */
`include "assert_macros.svh"
module srt_ctrl import srt_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	output logic      out_valid,
	input  logic      out_ready,
	input  srt_stat_t stat,
	output srt_cmd_t  cmd
);
	srt_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = ST_CHECK;
			end
			ST_CHECK: begin
				priority if (stat.is_read) state_d = ST_READ;
				else if (stat.skip) state_d = ST_OUT;
				else state_d = ST_FETCH;
			end
			ST_READ:      state_d = ST_READ_WAIT;
			ST_READ_WAIT: state_d = ST_OUT;
			ST_FETCH:     state_d = stat.more ? ST_LOAD : ST_TAIL;
			ST_LOAD:      state_d = ST_PH_LEFT;
			ST_PH_LEFT:   state_d = ST_PH_MID;
			ST_PH_MID:    state_d = ST_PH_RIGHT;
			ST_PH_RIGHT:  state_d = ST_FETCH;
			ST_TAIL:      state_d = ST_FINISH;
			ST_FINISH:    state_d = ST_OUT;
			ST_OUT: begin
				if (out_ready) state_d = ST_IDLE;
			end
			default:      state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd       = '0;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready    = 1'b1;
				cmd.capture = in_valid;
			end
			ST_CHECK: begin
				cmd.quick     = !stat.is_read && stat.skip;
				cmd.walk_init = !stat.is_read && !stat.skip;
			end
			ST_READ:      cmd.rd_idx = 1'b1;
			ST_READ_WAIT: cmd.read_take = 1'b1;
			ST_FETCH:     ;
			ST_LOAD:      cmd.load = 1'b1;
			ST_PH_LEFT: begin
				cmd.step  = 1'b1;
				cmd.phase = PH_LEFT;
			end
			ST_PH_MID: begin
				cmd.step  = 1'b1;
				cmd.phase = PH_MID;
			end
			ST_PH_RIGHT: begin
				cmd.step  = 1'b1;
				cmd.phase = PH_RIGHT;
			end
			ST_TAIL: begin
				cmd.step  = 1'b1;
				cmd.phase = PH_TAIL;
			end
			ST_FINISH:    cmd.commit = 1'b1;
			ST_OUT:       out_valid = 1'b1;
			default: ;
		endcase
	end

	`SRT_ASSERT_NEXT(a_accept_leaves_idle, cmd.capture, state_q == ST_CHECK, "accept did not start op")
	`SRT_ASSERT(a_no_overlap, !(in_ready && out_valid), "input open while result pending")
	`SRT_ASSERT_NEXT(a_commit_reports, cmd.commit, out_valid, "commit without result")
endmodule

/* rtl/srt_dp.sv */
`include "assert_macros.svh"
module srt_dp import srt_pkg::*; #(
	parameter int unsigned TABLE_DEPTH  = DefTableDepth,
	parameter int unsigned ADDRESS_BITS = DefAddressBits
) (
	input  logic              clk,
	input  logic              arst_n,
	input  srt_cmd_t          cmd,
	output srt_stat_t         stat,
	input  logic [1:0]        action,
	input  logic [StartW-1:0] range_start,
	input  logic [LenW-1:0]   range_length,
	input  logic [TagW-1:0]   region_tag,
	input  logic [IdxW-1:0]   read_index,
	output logic [1:0]        status,
	output logic [StartW-1:0] entry_start,
	output logic [LenW-1:0]   entry_length,
	output logic [TagW-1:0]   entry_tag,
	output logic              entry_valid,
	output logic [HeldW-1:0]  regions_held
);
	localparam int unsigned AW       = $clog2(TABLE_DEPTH);
	localparam int unsigned CntW     = AW + 1;
	localparam int unsigned RamDepth = 2 ** (AW + 1);
	localparam int unsigned WnW      = $clog2(2 * TABLE_DEPTH + 3);
	localparam int unsigned LimBits  = (ADDRESS_BITS < 48) ? ADDRESS_BITS : 48;
	localparam int unsigned CmpW     = (CntW > IdxW) ? CntW : IdxW;
	localparam logic [LenW:0] Limit  = (LenW + 1)'(1) << LimBits;

	srt_action_t       act_q;
	logic [StartW-1:0] s_q;
	logic [LenW-1:0]   len_q;
	logic [LenW-1:0]   e_q;
	logic [TagW-1:0]   tag_q;
	logic [IdxW-1:0]   idx_q;

	logic [StartW-1:0] a_q;
	logic [LenW-1:0]   b_q;
	logic [TagW-1:0]   pt_q;
	logic [LenW-1:0]   cur_q;
	logic              pend_q;
	logic [CntW-1:0]   i_q;
	logic [WnW-1:0]    wn_q;
	logic              bank_q;
	logic [CntW-1:0]   count_q;

	srt_status_t       status_q;
	logic [StartW-1:0] estart_q;
	logic [LenW-1:0]   elen_q;
	logic [TagW-1:0]   etag_q;
	logic              evalid_q;

	logic [LenW:0]     sum;
	logic              bad;
	logic              inc;
	logic [LenW-1:0]   a49, s49, lo;
	logic              emit, em_new, nxt_pend;
	logic [LenW-1:0]   em_s, em_e, nxt_cur, em_len;
	logic              we;
	logic [AW:0]       waddr, raddr;
	srt_entry_t        wdata, rdata;
	logic              rd_hit;

	assign sum = {2'b00, s_q} + {1'b0, len_q};
	assign bad = sum > Limit;
	assign inc = act_q == ACT_INCLUDE;
	assign a49 = {1'b0, a_q};
	assign s49 = {1'b0, s_q};

	assign stat.is_read = act_q == ACT_READ;
	assign stat.skip    = bad || (len_q == '0);
	assign stat.more    = i_q < count_q;

	// at most one output piece per step, in table order
	always_comb begin
		emit     = 1'b0;
		em_new   = 1'b0;
		em_s     = cur_q;
		em_e     = e_q;
		nxt_cur  = cur_q;
		nxt_pend = pend_q;
		lo       = (a49 > e_q) ? a49 : e_q;
		if (cmd.step) begin
			unique case (cmd.phase)
				PH_LEFT: begin
					if (inc) begin
						if (cur_q < e_q && a49 > cur_q) begin
							emit   = 1'b1;
							em_new = 1'b1;
							em_s   = cur_q;
							em_e   = (a49 < e_q) ? a49 : e_q;
						end
					end else if (a49 < s49) begin
						emit = 1'b1;
						em_s = a49;
						em_e = (b_q < s49) ? b_q : s49;
					end
				end
				PH_MID: begin
					if (inc) begin
						emit = 1'b1;
						em_s = a49;
						em_e = b_q;
						if (b_q > cur_q) nxt_cur = b_q;
					end else if (pend_q && b_q > s49) begin
						emit     = 1'b1;
						em_new   = 1'b1;
						em_s     = s49;
						em_e     = e_q;
						nxt_pend = 1'b0;
					end
				end
				PH_RIGHT: begin
					if (!inc && b_q > s49 && b_q > lo) begin
						emit = 1'b1;
						em_s = lo;
						em_e = b_q;
					end
				end
				PH_TAIL: begin
					if (inc) begin
						if (cur_q < e_q) begin
							emit   = 1'b1;
							em_new = 1'b1;
							em_s   = cur_q;
							em_e   = e_q;
						end
					end else if (pend_q) begin
						emit     = 1'b1;
						em_new   = 1'b1;
						em_s     = s49;
						em_e     = e_q;
						nxt_pend = 1'b0;
					end
				end
				default: ;
			endcase
		end
	end

	assign em_len      = em_e - em_s;
	assign we          = emit && (wn_q < WnW'(TABLE_DEPTH));
	assign waddr       = {~bank_q, wn_q[AW-1:0]};
	assign wdata.start = em_s[StartW-1:0];
	assign wdata.len   = em_len;
	assign wdata.tag   = em_new ? tag_q : pt_q;
	assign raddr       = cmd.rd_idx ? {bank_q, AW'(idx_q)} : {bank_q, i_q[AW-1:0]};
	assign rd_hit      = CmpW'(idx_q) < CmpW'(count_q);

	srt_ram #(
		.WIDTH($bits(srt_entry_t)),
		.DEPTH(RamDepth)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			act_q <= srt_action_t'(action);
			s_q   <= range_start;
			len_q <= range_length;
			tag_q <= region_tag;
			idx_q <= read_index;
		end
		if (cmd.walk_init) begin
			e_q <= sum[LenW-1:0];
		end
		if (cmd.load) begin
			a_q  <= rdata.start;
			b_q  <= {1'b0, rdata.start} + rdata.len;
			pt_q <= rdata.tag;
		end
		if (cmd.quick) begin
			estart_q <= '0;
			elen_q   <= '0;
			etag_q   <= '0;
			evalid_q <= 1'b0;
		end
		if (cmd.read_take) begin
			estart_q <= rd_hit ? rdata.start : '0;
			elen_q   <= rd_hit ? rdata.len : '0;
			etag_q   <= rd_hit ? rdata.tag : '0;
			evalid_q <= rd_hit;
		end
		if (cmd.commit) begin
			estart_q <= '0;
			elen_q   <= '0;
			etag_q   <= '0;
			evalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q    <= '0;
			pend_q   <= 1'b0;
			i_q      <= '0;
			wn_q     <= '0;
			bank_q   <= 1'b0;
			count_q  <= '0;
			status_q <= STAT_OK;
		end else begin
			if (cmd.walk_init) begin
				cur_q  <= s49;
				pend_q <= act_q == ACT_SET;
				i_q    <= '0;
				wn_q   <= '0;
			end
			if (cmd.load) i_q <= i_q + 1'b1;
			if (cmd.step) begin
				cur_q  <= nxt_cur;
				pend_q <= nxt_pend;
				if (emit) wn_q <= wn_q + 1'b1;
			end
			if (cmd.quick) status_q <= bad ? STAT_BAD_RANGE : STAT_OK;
			if (cmd.read_take) status_q <= STAT_OK;
			if (cmd.commit) begin
				if (wn_q > WnW'(TABLE_DEPTH)) begin
					status_q <= STAT_FULL;
				end else begin
					status_q <= STAT_OK;
					bank_q   <= ~bank_q;
					count_q  <= CntW'(wn_q);
				end
			end
		end
	end

	assign status       = status_q;
	assign entry_start  = estart_q;
	assign entry_length = elen_q;
	assign entry_tag    = etag_q;
	assign entry_valid  = evalid_q;
	assign regions_held = HeldW'(count_q);

	`SRT_ASSERT(a_count_bound, count_q <= CntW'(TABLE_DEPTH), "region count above depth")
	`SRT_ASSERT(a_write_shadow, !we || (waddr[AW] != bank_q), "write into live bank")
	`SRT_ASSERT_NEXT(a_commit_count, cmd.commit && (wn_q <= WnW'(TABLE_DEPTH)),
		count_q == CntW'($past(wn_q)), "count not taken from new table")
endmodule

/* verif/sorted_region_table_core_tb.sv */
module sorted_region_table_core_tb;
	import srt_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned TableDepth = DefTableDepth;
	localparam longint unsigned AddrLimit = 64'd1 << 48;
	localparam int unsigned IdleLimit = 20000;
	localparam int unsigned DrainCycles = 5 * TableDepth + 40;

	typedef struct {
		srt_action_t       action;
		logic [StartW-1:0] start;
		logic [LenW-1:0]   len;
		logic [TagW-1:0]   tag;
		logic [IdxW-1:0]   idx;
	} op_word_t;

	typedef struct {
		srt_status_t       status;
		logic [StartW-1:0] start;
		logic [LenW-1:0]   len;
		logic [TagW-1:0]   tag;
		logic              valid;
		logic [HeldW-1:0]  held;
	} rsp_word_t;

	typedef struct {
		longint unsigned s;
		longint unsigned n;
		logic [TagW-1:0] t;
	} span_t;

	logic clk;
	logic arst_n;

	srt_in_if  req ();
	srt_out_if rsp ();

	sorted_region_table_core u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req.sink),
		.rsp    (rsp.source)
	);

	op_word_t  pending_ops[$];
	rsp_word_t expected_rsp[$];
	span_t     regions[$];

	int unsigned errors;
	int unsigned ops_taken;
	int unsigned rsps_seen;
	int unsigned idle_cycles;
	int unsigned action_count[4];
	int unsigned full_count;
	int unsigned bad_count;
	int unsigned peak_regions;
	int unsigned src_gap;
	int unsigned sink_gap;
	bit          req_taken;
	bit          src_burst;
	bit          sink_burst;
	bit          stim_done;

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	function automatic int unsigned pick_gap(bit burst);
		int unsigned r;
		r = $urandom_range(0, 99);
		if (burst || r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic void push_span(ref span_t q[$], input longint unsigned s,
		input longint unsigned n, input logic [TagW-1:0] t);
		span_t p;
		if (n == 0)
			return;
		p.s = s;
		p.n = n;
		p.t = t;
		q.push_back(p);
	endfunction

	// Update the region list for one operation and return the word it yields.
	function automatic rsp_word_t apply_region_op(op_word_t op);
		rsp_word_t       r;
		span_t           cut[$];
		span_t           filled[$];
		longint unsigned s0, e0, a, b, cur;
		r = '{STAT_OK, '0, '0, '0, 1'b0, '0};
		s0 = op.start;
		e0 = s0 + longint'(op.len);
		if (op.action == ACT_READ) begin
			if (op.idx < regions.size()) begin
				r.start = regions[op.idx].s[StartW-1:0];
				r.len = regions[op.idx].n[LenW-1:0];
				r.tag = regions[op.idx].t;
				r.valid = 1'b1;
			end
		end else if (e0 > AddrLimit) begin
			r.status = STAT_BAD_RANGE;
		end else if (op.len != 0) begin
			if (op.action == ACT_INCLUDE) begin
				cut = regions;
			end else begin
				foreach (regions[i]) begin
					a = regions[i].s;
					b = a + regions[i].n;
					if (b <= s0 || a >= e0) begin
						push_span(cut, a, regions[i].n, regions[i].t);
					end else begin
						if (a < s0)
							push_span(cut, a, s0 - a, regions[i].t);
						if (b > e0)
							push_span(cut, e0, b - e0, regions[i].t);
					end
				end
			end
			if (op.action == ACT_EXCLUDE || cut.size() > TableDepth) begin
				filled = cut;
			end else begin
				cur = s0;
				foreach (cut[i]) begin
					a = cut[i].s;
					b = a + cut[i].n;
					if (cur < e0 && a > cur)
						push_span(filled, cur, (a < e0 ? a : e0) - cur, op.tag);
					filled.push_back(cut[i]);
					if (b > cur)
						cur = b;
				end
				if (cur < e0)
					push_span(filled, cur, e0 - cur, op.tag);
			end
			if (filled.size() > TableDepth)
				r.status = STAT_FULL;
			else
				regions = filled;
		end
		r.held = HeldW'(regions.size());
		return r;
	endfunction

	function automatic op_word_t make_op(srt_action_t act, longint unsigned s,
		longint unsigned n, int unsigned tag, int unsigned idx);
		op_word_t op;
		op.action = act;
		op.start = s[StartW-1:0];
		op.len = n[LenW-1:0];
		op.tag = tag[TagW-1:0];
		op.idx = idx[IdxW-1:0];
		return op;
	endfunction

	function automatic op_word_t random_op();
		op_word_t        op;
		int unsigned     r;
		longint unsigned s, n;
		r = $urandom_range(0, 99);
		if (r < 40)
			op.action = ACT_INCLUDE;
		else if (r < 65)
			op.action = ACT_EXCLUDE;
		else if (r < 80)
			op.action = ACT_SET;
		else
			op.action = ACT_READ;
		r = $urandom_range(0, 99);
		if (r < 90)
			s = $urandom_range(0, 4095);
		else if (r < 95)
			s = AddrLimit - $urandom_range(1, 64);
		else
			s = {$urandom, $urandom};
		r = $urandom_range(0, 99);
		if (r < 88)
			n = $urandom_range(1, 64);
		else if (r < 93)
			n = 0;
		else if (r < 97)
			n = $urandom_range(65, 2048);
		else
			n = {$urandom, $urandom};
		op.start = s[StartW-1:0];
		op.len = n[LenW-1:0];
		op.tag = TagW'($urandom);
		op.idx = IdxW'($urandom);
		return op;
	endfunction

	// Driver: present words from the pending list, with idle gaps.
	always @(negedge clk) begin
		op_word_t op;
		if (arst_n && (!req.valid || req_taken)) begin
			req_taken = 1'b0;
			if ($urandom_range(0, 199) == 0)
				src_burst = !src_burst;
			if (src_gap > 0) begin
				src_gap--;
				req.valid <= 1'b0;
			end else if (pending_ops.size() > 0) begin
				op = pending_ops.pop_front();
				req.action <= op.action;
				req.range_start <= op.start;
				req.range_length <= op.len;
				req.region_tag <= op.tag;
				req.read_index <= op.idx;
				req.valid <= 1'b1;
				src_gap = pick_gap(src_burst);
			end else begin
				req.valid <= 1'b0;
			end
		end
	end

	// Result side backpressure.
	always @(negedge clk) begin
		if (arst_n) begin
			if ($urandom_range(0, 199) == 0)
				sink_burst = !sink_burst;
			if (sink_gap > 0) begin
				sink_gap--;
				rsp.ready <= 1'b0;
			end else begin
				rsp.ready <= 1'b1;
				sink_gap = pick_gap(sink_burst);
			end
		end
	end

	// Predict on each accepted request word.
	always @(posedge clk) begin
		op_word_t  op;
		rsp_word_t r;
		if (arst_n && req.valid && req.ready) begin
			op.action = srt_action_t'(req.action);
			op.start = req.range_start;
			op.len = req.range_length;
			op.tag = req.region_tag;
			op.idx = req.read_index;
			r = apply_region_op(op);
			expected_rsp.push_back(r);
			action_count[op.action]++;
			if (r.status == STAT_FULL)
				full_count++;
			if (r.status == STAT_BAD_RANGE)
				bad_count++;
			if (regions.size() > peak_regions)
				peak_regions = regions.size();
			ops_taken++;
			req_taken = 1'b1;
		end
	end

	// Monitor: compare each delivered result word with the oldest prediction.
	always @(posedge clk) begin
		rsp_word_t x;
		if (arst_n && rsp.valid && rsp.ready) begin
			rsps_seen++;
			if (expected_rsp.size() == 0) begin
				$error("result word with nothing expected");
				errors++;
			end else begin
				x = expected_rsp.pop_front();
				if (rsp.status !== x.status) begin
					$error("status: expected %0d, got %0d", x.status, rsp.status);
					errors++;
				end
				if (rsp.entry_start !== x.start) begin
					$error("entry_start: expected %h, got %h", x.start, rsp.entry_start);
					errors++;
				end
				if (rsp.entry_length !== x.len) begin
					$error("entry_length: expected %h, got %h", x.len, rsp.entry_length);
					errors++;
				end
				if (rsp.entry_tag !== x.tag) begin
					$error("entry_tag: expected %0d, got %0d", x.tag, rsp.entry_tag);
					errors++;
				end
				if (rsp.entry_valid !== x.valid) begin
					$error("entry_valid: expected %0d, got %0d", x.valid, rsp.entry_valid);
					errors++;
				end
				if (rsp.regions_held !== x.held) begin
					$error("regions_held: expected %0d, got %0d", x.held, rsp.regions_held);
					errors++;
				end
			end
		end
	end

	// Watchdog: stop if no word moves on either side for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || (!req.valid
				&& expected_rsp.size() == 0 && !stim_done))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IdleLimit && !stim_done) begin
				$display("sorted_region_table_core regression: fail");
				$finish;
			end
		end
	end

	initial begin
		longint unsigned full_len;
		int unsigned     k;
		full_len = AddrLimit;
		errors = 0;
		ops_taken = 0;
		rsps_seen = 0;
		idle_cycles = 0;
		full_count = 0;
		bad_count = 0;
		peak_regions = 0;
		src_gap = 0;
		sink_gap = 0;
		req_taken = 1'b0;
		src_burst = 1'b0;
		sink_burst = 1'b0;
		stim_done = 1'b0;
		for (int i = 0; i < 4; i++)
			action_count[i] = 0;
		arst_n = 1'b0;
		req.valid = 1'b0;
		req.action = ACT_INCLUDE;
		req.range_start = '0;
		req.range_length = '0;
		req.region_tag = '0;
		req.read_index = '0;
		rsp.ready = 1'b0;

		// Directed: zero length, whole space, top byte, bad ranges, reads off the end.
		pending_ops.push_back(make_op(ACT_INCLUDE, 0, 0, 3, 0));
		pending_ops.push_back(make_op(ACT_READ, 0, 0, 0, 0));
		pending_ops.push_back(make_op(ACT_INCLUDE, 0, full_len, 15, 0));
		pending_ops.push_back(make_op(ACT_READ, 0, 0, 0, 0));
		pending_ops.push_back(make_op(ACT_READ, 0, 0, 0, 255));
		pending_ops.push_back(make_op(ACT_EXCLUDE, AddrLimit - 1, 1, 0, 0));
		pending_ops.push_back(make_op(ACT_SET, 100, 50, 5, 0));
		pending_ops.push_back(make_op(ACT_READ, 0, 0, 0, 0));
		pending_ops.push_back(make_op(ACT_READ, 0, 0, 0, 1));
		pending_ops.push_back(make_op(ACT_READ, 0, 0, 0, 2));
		pending_ops.push_back(make_op(ACT_INCLUDE, 120, 10, 9, 0));
		pending_ops.push_back(make_op(ACT_EXCLUDE, 0, full_len, 0, 0));
		pending_ops.push_back(make_op(ACT_INCLUDE, AddrLimit - 1, 2, 1, 0));
		pending_ops.push_back(make_op(ACT_INCLUDE, 1, full_len, 1, 0));
		pending_ops.push_back(make_op(ACT_SET, AddrLimit - 5, 9, 2, 0));
		pending_ops.push_back(make_op(ACT_EXCLUDE, AddrLimit - 1, 2, 0, 0));
		pending_ops.push_back(make_op(ACT_INCLUDE, AddrLimit - 1, (64'd1 << 49) - 1, 15, 0));
		pending_ops.push_back(make_op(ACT_INCLUDE, AddrLimit - 1, 1, 10, 0));
		pending_ops.push_back(make_op(ACT_SET, 0, 0, 6, 0));
		pending_ops.push_back(make_op(ACT_EXCLUDE, 5, 0, 0, 0));
		pending_ops.push_back(make_op(ACT_READ, 0, 0, 0, 0));
		pending_ops.push_back(make_op(ACT_READ, 0, 0, 0, 1));
		pending_ops.push_back(make_op(ACT_EXCLUDE, 0, full_len, 0, 0));

		for (int i = 0; i < 1420; i++) begin
			if (i == 700) begin
				// Build a full table of short regions, then force overflows.
				for (k = 0; k < TableDepth; k++)
					pending_ops.push_back(make_op(ACT_INCLUDE, 4 * k, 3, k % 16, 0));
				pending_ops.push_back(make_op(ACT_EXCLUDE, 41, 1, 0, 0));
				pending_ops.push_back(make_op(ACT_SET, 81, 1, 7, 0));
				pending_ops.push_back(make_op(ACT_INCLUDE, 0, 1024, 4, 0));
				pending_ops.push_back(make_op(ACT_SET, 40, 8, 4, 0));
				pending_ops.push_back(make_op(ACT_READ, 0, 0, 0, 255));
				pending_ops.push_back(make_op(ACT_EXCLUDE, 0, 2048, 0, 0));
			end
			pending_ops.push_back(random_op());
		end

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		wait (pending_ops.size() == 0 && !req.valid && expected_rsp.size() == 0);
		stim_done = 1'b1;
		repeat (DrainCycles) @(posedge clk);
		if (expected_rsp.size() != 0) begin
			$error("%0d result words never arrived", expected_rsp.size());
			errors++;
		end
		$display("ran %0d ops (include %0d, exclude %0d, set %0d, read %0d), %0d results",
			ops_taken, action_count[ACT_INCLUDE], action_count[ACT_EXCLUDE],
			action_count[ACT_SET], action_count[ACT_READ], rsps_seen);
		$display("table full %0d times, bad range %0d times, up to %0d regions held",
			full_count, bad_count, peak_regions);
		if (errors == 0)
			$display("sorted_region_table_core regression: pass");
		else
			$display("sorted_region_table_core regression: fail");
		$finish;
	end
endmodule
